### design/lbw_pkg.sv
package lbw_pkg;

   localparam int NUM_DIR   = 5;
   localparam int DIR_REST  = 0;
   localparam int DIR_EAST  = 1;
   localparam int DIR_NORTH = 2;
   localparam int DIR_WEST  = 3;
   localparam int DIR_SOUTH = 4;

   typedef logic signed [31:0] q16_type;      // signed Q16.16 distribution
   typedef logic signed [36:0] feq_type;      // equilibrium before clipping
   typedef logic signed [50:0] prod_f_type;   // (1 - inv_tau) * f
   typedef logic signed [55:0] prod_e_type;   // inv_tau * feq
   typedef logic signed [47:0] wide_type;     // rounded value before clipping

   typedef enum logic [1:0] {
      KIND_FLUID  = 2'd0,
      KIND_MIRROR = 2'd1,
      KIND_SOURCE = 2'd2
   } cell_kind_type;

   typedef enum logic [2:0] {
      CSR_C_SQ        = 3'd0,
      CSR_INV_TAU     = 3'd1,
      CSR_MIRROR_CX   = 3'd2,
      CSR_MIRROR_CY   = 3'd3,
      CSR_MIRROR_R2   = 3'd4,
      CSR_MIRROR_XMIN = 3'd5,
      CSR_MIRROR_XMAX = 3'd6
   } csr_index_type;

   localparam logic [15:0] C_SQ_RESET        = 16'd16384;
   localparam logic [17:0] INV_TAU_RESET     = 18'd131072;
   localparam logic [9:0]  MIRROR_CX_RESET   = 10'd50;
   localparam logic [7:0]  MIRROR_CY_RESET   = 8'd100;
   localparam logic [20:0] MIRROR_R2_RESET   = 21'd10000;
   localparam logic [9:0]  MIRROR_XMIN_RESET = 10'd50;
   localparam logic [9:0]  MIRROR_XMAX_RESET = 10'd200;

   typedef struct packed {
      logic [15:0] c_sq;
      logic [17:0] inv_tau;
      logic [9:0]  mirror_cx;
      logic [7:0]  mirror_cy;
      logic [20:0] mirror_r2;
      logic [9:0]  mirror_xmin;
      logic [9:0]  mirror_xmax;
   } cfg_type;

   typedef struct packed {
      logic [9:0] pos_x;
      logic [7:0] pos_y;
      q16_type    f_rest;
      q16_type    f_east;
      q16_type    f_north;
      q16_type    f_west;
      q16_type    f_south;
      q16_type    source_density;
   } req_type;

   typedef struct packed {
      q16_type       new_rest;
      q16_type       new_east;
      q16_type       new_north;
      q16_type       new_west;
      q16_type       new_south;
      cell_kind_type cell_kind;
      logic          saturated;
   } rsp_type;

   // moments of one cell
   typedef struct packed {
      q16_type [NUM_DIR-1:0] f;
      logic signed [34:0]    rho;
      logic signed [32:0]    jx;
      logic signed [32:0]    jy;
      logic signed [10:0]    dx;
      logic signed [8:0]     dy;
      logic                  is_src;
      logic                  in_x;
   } mom_type;

   typedef struct packed {
      q16_type [NUM_DIR-1:0] f;
      logic signed [32:0]    jx;
      logic signed [32:0]    jy;
      logic signed [52:0]    p_rest;
      logic signed [51:0]    p_cs;
      logic [19:0]           sq_x;
      logic [15:0]           sq_y;
      logic                  is_src;
      logic                  in_x;
   } prod_type;

   typedef struct packed {
      q16_type [NUM_DIR-1:0] f;
      feq_type [NUM_DIR-1:0] feq;
      cell_kind_type         kind;
   } eq_type;

   typedef struct packed {
      prod_f_type [NUM_DIR-1:0] pa;
      prod_e_type [NUM_DIR-1:0] pb;
      q16_type    [NUM_DIR-1:0] f;
      feq_type    [NUM_DIR-1:0] feq;
      cell_kind_type            kind;
   } relax_type;

   typedef struct packed {
      q16_type value;
      logic    clip;
   } sat_type;

   function automatic sat_type sat_q16(input wide_type v);
      sat_type r;
      if (v > 48'sd2147483647) begin
         r.value = 32'sh7FFF_FFFF;
         r.clip  = 1'b1;
      end else if (v < -48'sd2147483648) begin
         r.value = 32'sh8000_0000;
         r.clip  = 1'b1;
      end else begin
         r.value = v[31:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

### design/lattice_boltzmann_d2q5_wave_cell_unit.sv
// An item passes the req, mom, prod, eq, relax and rsp registers before its result shows.
// Throughput: one item per cycle when not stalled; six register stages, the deepest being
// the 37 x 19 bit multipliers of the relaxation and the 35 x 18 bit equilibrium products.
// A stalled result holds only the stages behind it that are full; bubbles still fill.
// Reset (synchronous, active high) empties every stage and loads the register defaults.
module lattice_boltzmann_d2q5_wave_cell_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lbw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lbw_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   lbw_pkg::cfg_type cfg;
   lbw_pkg::mom_type mom_data;
   lbw_pkg::eq_type  eq_data;
   logic             mom_valid, mom_hold;
   logic             eq_valid, eq_hold;

   lbw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbw_moments u_moments (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_hold   (req_stall),
      .out_valid (mom_valid),
      .out_data  (mom_data),
      .out_hold  (mom_hold)
   );

   lbw_equil u_equil (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mom_valid),
      .in_data   (mom_data),
      .in_hold   (mom_hold),
      .out_valid (eq_valid),
      .out_data  (eq_data),
      .out_hold  (eq_hold)
   );

   lbw_relax u_relax (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (eq_valid),
      .in_data   (eq_data),
      .in_hold   (eq_hold),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_hold  (rsp_stall)
   );

endmodule

### design/lbw_csr.sv
module lbw_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output lbw_pkg::cfg_type cfg
);

   lbw_pkg::cfg_type cfg_ff;
   lbw_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lbw_pkg::CSR_C_SQ:        cfg_in.c_sq        = csr_wdata[15:0];
            lbw_pkg::CSR_INV_TAU:     cfg_in.inv_tau     = csr_wdata[17:0];
            lbw_pkg::CSR_MIRROR_CX:   cfg_in.mirror_cx   = csr_wdata[9:0];
            lbw_pkg::CSR_MIRROR_CY:   cfg_in.mirror_cy   = csr_wdata[7:0];
            lbw_pkg::CSR_MIRROR_R2:   cfg_in.mirror_r2   = csr_wdata[20:0];
            lbw_pkg::CSR_MIRROR_XMIN: cfg_in.mirror_xmin = csr_wdata[9:0];
            lbw_pkg::CSR_MIRROR_XMAX: cfg_in.mirror_xmax = csr_wdata[9:0];
            default:                  cfg_in = cfg_ff;   // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_sq        <= lbw_pkg::C_SQ_RESET;
         cfg_ff.inv_tau     <= lbw_pkg::INV_TAU_RESET;
         cfg_ff.mirror_cx   <= lbw_pkg::MIRROR_CX_RESET;
         cfg_ff.mirror_cy   <= lbw_pkg::MIRROR_CY_RESET;
         cfg_ff.mirror_r2   <= lbw_pkg::MIRROR_R2_RESET;
         cfg_ff.mirror_xmin <= lbw_pkg::MIRROR_XMIN_RESET;
         cfg_ff.mirror_xmax <= lbw_pkg::MIRROR_XMAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/lbw_moments.sv
module lbw_moments (
   input  logic             clock,
   input  logic             reset,
   input  lbw_pkg::cfg_type cfg,
   input  logic             in_valid,
   input  lbw_pkg::req_type in_data,
   output logic             in_hold,
   output logic             out_valid,
   output lbw_pkg::mom_type out_data,
   input  logic             out_hold
);

   logic             valid_a_ff, valid_a_in;
   logic             valid_b_ff, valid_b_in;
   lbw_pkg::req_type req_ff, req_in;
   lbw_pkg::mom_type mom_ff, mom_in;
   logic             hold_a, hold_b;

   assign hold_b    = valid_b_ff & out_hold;
   assign hold_a    = valid_a_ff & hold_b;
   assign in_hold   = hold_a;
   assign out_valid = valid_b_ff;
   assign out_data  = mom_ff;

   always_comb begin
      valid_a_in = hold_a ? valid_a_ff : in_valid;
      req_in     = (hold_a || !in_valid) ? req_ff : in_data;
      valid_b_in = hold_b ? valid_b_ff : valid_a_ff;
   end

   always_comb begin
      logic signed [34:0] rho_sum;
      mom_in = mom_ff;
      if (!hold_b && valid_a_ff) begin
         mom_in.f[lbw_pkg::DIR_REST]  = req_ff.f_rest;
         mom_in.f[lbw_pkg::DIR_EAST]  = req_ff.f_east;
         mom_in.f[lbw_pkg::DIR_NORTH] = req_ff.f_north;
         mom_in.f[lbw_pkg::DIR_WEST]  = req_ff.f_west;
         mom_in.f[lbw_pkg::DIR_SOUTH] = req_ff.f_south;
         rho_sum = 35'(req_ff.f_rest) + 35'(req_ff.f_east) + 35'(req_ff.f_north)
                 + 35'(req_ff.f_west) + 35'(req_ff.f_south);
         mom_in.is_src = (req_ff.pos_x == 10'd0);
         // source column takes the imposed density in place of its own sum
         mom_in.rho    = mom_in.is_src ? 35'(req_ff.source_density) : rho_sum;
         mom_in.jx     = 33'(req_ff.f_east) - 33'(req_ff.f_west);
         mom_in.jy     = 33'(req_ff.f_north) - 33'(req_ff.f_south);
         mom_in.dx     = $signed({1'b0, req_ff.pos_x}) - $signed({1'b0, cfg.mirror_cx});
         mom_in.dy     = $signed({1'b0, req_ff.pos_y}) - $signed({1'b0, cfg.mirror_cy});
         mom_in.in_x   = (req_ff.pos_x > cfg.mirror_xmin) && (req_ff.pos_x < cfg.mirror_xmax);
      end else begin
         rho_sum = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      mom_ff <= mom_in;
   end

endmodule

### design/lbw_equil.sv
module lbw_equil (
   input  logic              clock,
   input  logic              reset,
   input  lbw_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  lbw_pkg::mom_type  in_data,
   output logic              in_hold,
   output logic              out_valid,
   output lbw_pkg::eq_type   out_data,
   input  logic              out_hold
);

   logic              valid_a_ff, valid_a_in;
   logic              valid_b_ff, valid_b_in;
   lbw_pkg::prod_type prod_ff, prod_in;
   lbw_pkg::eq_type   eq_ff, eq_in;
   logic              hold_a, hold_b;

   assign hold_b    = valid_b_ff & out_hold;
   assign hold_a    = valid_a_ff & hold_b;
   assign in_hold   = hold_a;
   assign out_valid = valid_b_ff;
   assign out_data  = eq_ff;

   always_comb begin
      valid_a_in = hold_a ? valid_a_ff : in_valid;
      valid_b_in = hold_b ? valid_b_ff : valid_a_ff;
   end

   // products: rest weight, c_sq * rho and the squared circle offsets
   always_comb begin
      logic signed [17:0] w_rest;
      logic signed [21:0] sq_x_full;
      logic signed [17:0] sq_y_full;
      w_rest    = 18'sd65536 - $signed({1'b0, cfg.c_sq, 1'b0});
      sq_x_full = 22'(in_data.dx) * 22'(in_data.dx);
      sq_y_full = 18'(in_data.dy) * 18'(in_data.dy);
      prod_in   = prod_ff;
      if (!hold_a && in_valid) begin
         prod_in.f      = in_data.f;
         prod_in.jx     = in_data.jx;
         prod_in.jy     = in_data.jy;
         prod_in.p_rest = 53'(in_data.rho) * 53'(w_rest);
         prod_in.p_cs   = 52'(in_data.rho) * 52'($signed({1'b0, cfg.c_sq}));
         prod_in.sq_x   = sq_x_full[19:0];
         prod_in.sq_y   = sq_y_full[15:0];
         prod_in.is_src = in_data.is_src;
         prod_in.in_x   = in_data.in_x;
      end
   end

   // equilibrium, rounded to nearest with halves upward, and the cell kind
   always_comb begin
      logic signed [53:0] t_rest;
      logic signed [53:0] t_mov;
      logic signed [33:0] ej [lbw_pkg::NUM_DIR];
      logic [20:0]        rad_sq;
      logic               mirror;
      ej[lbw_pkg::DIR_REST]  = '0;
      ej[lbw_pkg::DIR_EAST]  = 34'(prod_ff.jx);
      ej[lbw_pkg::DIR_NORTH] = 34'(prod_ff.jy);
      ej[lbw_pkg::DIR_WEST]  = -34'(prod_ff.jx);
      ej[lbw_pkg::DIR_SOUTH] = -34'(prod_ff.jy);
      t_rest = 54'(prod_ff.p_rest) + 54'sd32768;
      t_mov  = '0;
      rad_sq = {1'b0, prod_ff.sq_x} + {5'b0, prod_ff.sq_y};
      mirror = prod_ff.in_x && (rad_sq > cfg.mirror_r2);
      eq_in  = eq_ff;
      if (!hold_b && valid_a_ff) begin
         eq_in.f = prod_ff.f;
         eq_in.feq[lbw_pkg::DIR_REST] = 37'(t_rest >>> 16);
         for (int d = 1; d < lbw_pkg::NUM_DIR; d++) begin
            t_mov = 54'(prod_ff.p_cs) + (54'(ej[d]) <<< 16) + 54'sd65536;
            eq_in.feq[d] = 37'(t_mov >>> 17);
         end
         if (prod_ff.is_src) begin
            eq_in.kind = lbw_pkg::KIND_SOURCE;
         end else if (mirror) begin
            eq_in.kind = lbw_pkg::KIND_MIRROR;
         end else begin
            eq_in.kind = lbw_pkg::KIND_FLUID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      eq_ff   <= eq_in;
   end

endmodule

### design/lbw_relax.sv
module lbw_relax (
   input  logic               clock,
   input  logic               reset,
   input  lbw_pkg::cfg_type   cfg,
   input  logic               in_valid,
   input  lbw_pkg::eq_type    in_data,
   output logic               in_hold,
   output logic               out_valid,
   output lbw_pkg::rsp_type   out_data,
   input  logic               out_hold
);

   logic               valid_a_ff, valid_a_in;
   logic               valid_b_ff, valid_b_in;
   lbw_pkg::relax_type relax_ff, relax_in;
   lbw_pkg::rsp_type   rsp_ff, rsp_in;
   logic               hold_a, hold_b;

   assign hold_b    = valid_b_ff & out_hold;
   assign hold_a    = valid_a_ff & hold_b;
   assign in_hold   = hold_a;
   assign out_valid = valid_b_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      valid_a_in = hold_a ? valid_a_ff : in_valid;
      valid_b_in = hold_b ? valid_b_ff : valid_a_ff;
   end

   // weighted terms of the relaxation, one pair of multipliers per direction
   always_comb begin
      logic signed [18:0] it_s;
      logic signed [18:0] one_m;
      it_s     = $signed({1'b0, cfg.inv_tau});
      one_m    = 19'sd65536 - it_s;
      relax_in = relax_ff;
      if (!hold_a && in_valid) begin
         for (int d = 0; d < lbw_pkg::NUM_DIR; d++) begin
            relax_in.pa[d] = 51'(one_m) * 51'(in_data.f[d]);
            relax_in.pb[d] = 56'(it_s) * 56'(in_data.feq[d]);
         end
         relax_in.f    = in_data.f;
         relax_in.feq  = in_data.feq;
         relax_in.kind = in_data.kind;
      end
   end

   // round, clip and pick the result by cell kind
   always_comb begin
      logic signed [56:0]              acc;
      lbw_pkg::sat_type                s;
      lbw_pkg::q16_type [lbw_pkg::NUM_DIR-1:0] nv;
      logic                            clip;
      acc  = '0;
      s    = '0;
      nv   = '0;
      clip = 1'b0;
      case (relax_ff.kind)
         lbw_pkg::KIND_MIRROR: begin
            // bounce-back: swap opposite directions, never clipped
            nv[lbw_pkg::DIR_REST]  = relax_ff.f[lbw_pkg::DIR_REST];
            nv[lbw_pkg::DIR_EAST]  = relax_ff.f[lbw_pkg::DIR_WEST];
            nv[lbw_pkg::DIR_NORTH] = relax_ff.f[lbw_pkg::DIR_SOUTH];
            nv[lbw_pkg::DIR_WEST]  = relax_ff.f[lbw_pkg::DIR_EAST];
            nv[lbw_pkg::DIR_SOUTH] = relax_ff.f[lbw_pkg::DIR_NORTH];
         end
         lbw_pkg::KIND_SOURCE: begin
            for (int d = 0; d < lbw_pkg::NUM_DIR; d++) begin
               s     = lbw_pkg::sat_q16(48'(relax_ff.feq[d]));
               nv[d] = s.value;
               clip  = clip | s.clip;
            end
         end
         default: begin
            for (int d = 0; d < lbw_pkg::NUM_DIR; d++) begin
               acc   = 57'(relax_ff.pa[d]) + 57'(relax_ff.pb[d]) + 57'sd32768;
               s     = lbw_pkg::sat_q16(48'(acc >>> 16));
               nv[d] = s.value;
               clip  = clip | s.clip;
            end
         end
      endcase
      rsp_in = rsp_ff;
      if (!hold_b && valid_a_ff) begin
         rsp_in.new_rest  = nv[lbw_pkg::DIR_REST];
         rsp_in.new_east  = nv[lbw_pkg::DIR_EAST];
         rsp_in.new_north = nv[lbw_pkg::DIR_NORTH];
         rsp_in.new_west  = nv[lbw_pkg::DIR_WEST];
         rsp_in.new_south = nv[lbw_pkg::DIR_SOUTH];
         rsp_in.cell_kind = relax_ff.kind;
         rsp_in.saturated = clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      relax_ff <= relax_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### design/lbw_checker.sv
module lbw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lbw_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or vanished");

   a_mirror_unclipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.cell_kind == lbw_pkg::KIND_MIRROR) |-> !rsp_data.saturated)
      else $error("bounce-back item flagged as clipped");

   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled while the output is free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind lattice_boltzmann_d2q5_wave_cell_unit lbw_checker u_lbw_checker (.*);
